[hdl/dct_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath handshake types for the divisor count table.
package dct_pkg;

    localparam int TABLE_SIZE = 65536;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int POS_W      = ADDR_W + 2;
    localparam int NUM_W      = 16;
    localparam int CNT_W      = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    localparam logic MODE_BUILD = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_SIEVE = 6'b000100,
        S_DRAIN = 6'b001000,
        S_ANS   = 6'b010000,
        S_ACK   = 6'b100000
    } t_state;

    typedef struct packed {
        logic start_query;
        logic start_build;
        logic clear;
        logic sieve;
        logic set_built;
        logic load_ans;
        logic load_ack;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic pos_last;
        logic step_last;
        logic out_free;
    } t_stat;

endpackage

[hdl/dct_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response beats.
interface dct_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [dct_pkg::NUM_W-1:0] number;

    modport source (output valid, output mode, output number, input ready);
    modport sink   (input valid, input mode, input number, output ready);
endinterface

interface dct_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [dct_pkg::CNT_W-1:0] divisor_count;
    logic                      is_answer;

    modport source (output valid, output divisor_count, output is_answer, input ready);
    modport sink   (input valid, input divisor_count, input is_answer, output ready);
endinterface

[hdl/dct_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine that sequences queries and table rebuilds.
module dct_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_mode,
    output logic           o_in_ready,
    input  dct_pkg::t_stat i_stat,
    output dct_pkg::t_cmd  o_cmd
);

    dct_pkg::t_state r_state;
    dct_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dct_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dct_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == dct_pkg::MODE_QUERY) begin
                        o_cmd.start_query = 1'b1;
                        n_state           = dct_pkg::S_ANS;
                    end else begin
                        o_cmd.start_build = 1'b1;
                        n_state           = dct_pkg::S_CLEAR;
                    end
                end
            end
            dct_pkg::S_CLEAR: begin
                // The first sieve pass touches every entry, so it also clears the table.
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = (dct_pkg::TABLE_SIZE > 2) ? dct_pkg::S_SIEVE : dct_pkg::S_DRAIN;
                end
            end
            dct_pkg::S_SIEVE: begin
                o_cmd.sieve = 1'b1;
                if (i_stat.pos_last && i_stat.step_last) begin
                    n_state = dct_pkg::S_DRAIN;
                end
            end
            dct_pkg::S_DRAIN: begin
                o_cmd.set_built = 1'b1;
                n_state         = dct_pkg::S_ACK;
            end
            dct_pkg::S_ANS: begin
                if (i_stat.out_free) begin
                    o_cmd.load_ans = 1'b1;
                    n_state        = dct_pkg::S_IDLE;
                end
            end
            dct_pkg::S_ACK: begin
                if (i_stat.out_free) begin
                    o_cmd.load_ack = 1'b1;
                    n_state        = dct_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dct_pkg::S_IDLE;
            end
        endcase
    end

    a_query_to_ans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dct_pkg::S_IDLE && i_in_valid && i_in_mode == dct_pkg::MODE_QUERY)
        |=> (r_state == dct_pkg::S_ANS))
        else $error("query beat did not move to the answer state");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_ans || o_cmd.load_ack) |-> i_stat.out_free)
        else $error("output register loaded while occupied");

    a_sieve_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dct_pkg::S_SIEVE && i_stat.pos_last && i_stat.step_last)
        |=> (r_state == dct_pkg::S_DRAIN))
        else $error("sieve did not finish into the drain state");

endmodule

[hdl/dct_datapath.sv]
`timescale 1ns / 1ps
// Datapath: count memory, sieve walk counters, read-modify-write stage and output register.
module dct_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dct_pkg::t_cmd             i_cmd,
    output dct_pkg::t_stat            o_stat,
    input  logic [dct_pkg::NUM_W-1:0] i_number,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [dct_pkg::CNT_W-1:0] o_divisor_count,
    output logic                      o_is_answer
);

    logic [dct_pkg::CNT_W-1:0] r_mem [dct_pkg::TABLE_SIZE];

    logic [dct_pkg::POS_W-1:0]  r_pos;
    logic [dct_pkg::POS_W-1:0]  r_step;
    logic [dct_pkg::ADDR_W-1:0] r_wr_addr;
    logic                       r_wr_pend;
    logic [dct_pkg::CNT_W-1:0]  r_rd_data;
    logic                       r_built;
    logic                       r_in_range;
    logic                       r_out_valid;
    logic [dct_pkg::CNT_W-1:0]  r_out_count;
    logic                       r_out_ans;

    logic [dct_pkg::POS_W-1:0]         pos_next;
    logic [dct_pkg::POS_W-1:0]         step_next;
    logic [dct_pkg::ADDR_W-1:0]        rd_addr;
    logic [dct_pkg::CNT_W-1:0]         inc_data;
    logic [dct_pkg::CNT_W-1:0]         clr_data;
    logic [dct_pkg::NUM_W+dct_pkg::POS_W-1:0] num_ext;
    logic                              num_in_range;
    logic [dct_pkg::CNT_W-1:0]         ans_count;

    assign pos_next  = r_pos + r_step;
    assign step_next = r_step + dct_pkg::POS_W'(1);

    assign o_stat.clear_last = (r_pos == dct_pkg::POS_W'(dct_pkg::TABLE_SIZE - 1));
    assign o_stat.pos_last   = (pos_next >= dct_pkg::POS_W'(dct_pkg::TABLE_SIZE));
    assign o_stat.step_last  = (step_next >= dct_pkg::POS_W'(dct_pkg::TABLE_SIZE));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign num_ext      = (dct_pkg::NUM_W + dct_pkg::POS_W)'(i_number);
    assign num_in_range = (num_ext < (dct_pkg::NUM_W + dct_pkg::POS_W)'(dct_pkg::TABLE_SIZE));

    assign rd_addr  = i_cmd.sieve ? r_pos[dct_pkg::ADDR_W-1:0]
                                  : dct_pkg::ADDR_W'(i_number);
    assign inc_data = (r_rd_data == dct_pkg::COUNT_MAX) ? dct_pkg::COUNT_MAX
                                                        : r_rd_data + dct_pkg::CNT_W'(1);
    // Entry zero has no divisors; every other entry is divisible by one.
    assign clr_data = (r_pos == '0) ? '0 : dct_pkg::CNT_W'(1);

    // Before the first rebuild the memory holds garbage, which reads as the reset value of zero.
    assign ans_count = (r_built && r_in_range) ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_pos[dct_pkg::ADDR_W-1:0]] <= clr_data;
        end else if (r_wr_pend) begin
            r_mem[r_wr_addr] <= inc_data;
        end
        if (i_cmd.sieve || i_cmd.start_query) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_build) begin
            r_pos  <= '0;
            r_step <= dct_pkg::POS_W'(1);
        end else if (i_cmd.clear) begin
            if (o_stat.clear_last) begin
                r_pos  <= dct_pkg::POS_W'(2);
                r_step <= dct_pkg::POS_W'(2);
            end else begin
                r_pos <= r_pos + dct_pkg::POS_W'(1);
            end
        end else if (i_cmd.sieve) begin
            if (o_stat.pos_last) begin
                r_pos  <= step_next;
                r_step <= step_next;
            end else begin
                r_pos <= pos_next;
            end
        end
        if (i_cmd.sieve) begin
            r_wr_addr <= r_pos[dct_pkg::ADDR_W-1:0];
        end
        if (i_cmd.start_query) begin
            r_in_range <= num_in_range;
        end
        if (i_cmd.load_ans || i_cmd.load_ack) begin
            r_out_count <= i_cmd.load_ans ? ans_count : '0;
            r_out_ans   <= i_cmd.load_ans;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend   <= 1'b0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.sieve;
            if (i_cmd.set_built) begin
                r_built <= 1'b1;
            end
            if (i_cmd.load_ans || i_cmd.load_ack) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_divisor_count = r_out_count;
    assign o_is_answer     = r_out_ans;

    a_no_clear_during_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clear && r_wr_pend))
        else $error("clear write collided with a pending increment");

    a_wr_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sieve |=> r_wr_pend)
        else $error("sieve read not followed by its write back");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_ans || i_cmd.load_ack) |=> r_out_valid)
        else $error("output register load did not raise valid");

endmodule

[hdl/divisor_count_table_top.sv]
`timescale 1ns / 1ps
// Top level of the divisor count table: joins the controller and the datapath to the channels.
// A query beat is worked by one registered read of the count memory and then a load of the
// output register, which waits while that register holds a result that is not yet taken. A rebuild
// beat walks the harmonic sieve through the single read and write port of the memory: one pass
// writes every entry (this also clears it), then each step i from 2 to TABLE_SIZE-1 reads and
// rewrites every multiple of i below TABLE_SIZE. One beat is worked at a time; a result that
// waits in the output register does not block acceptance of the next request beat. Queries made
// before the first rebuild answer 0 without any clearing pass after reset.
module divisor_count_table_top (
    input  logic i_clk,
    input  logic i_rst_n,
    dct_req_if.sink   i_req,
    dct_rsp_if.source o_rsp
);

    dct_pkg::t_cmd  cmd;
    dct_pkg::t_stat stat;

    dct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_mode  (i_req.mode),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dct_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_number        (i_req.number),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_divisor_count (o_rsp.divisor_count),
        .o_is_answer     (o_rsp.is_answer)
    );

endmodule
